@@ src/cosp_pkg.sv @@
`default_nettype none
package cosp_pkg;

    localparam int unsigned CORDIC_ITERS = 30;
    localparam int unsigned ANG_W        = 34;
    localparam int unsigned VEC_W        = 34;

    localparam logic signed [26:0] ORBIT_R   = 27'sd25478136;
    localparam logic [32:0]        RATE48    = 33'd6949982493;
    localparam logic signed [VEC_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [31:0] COS_INC    = 32'sd457177033;
    localparam logic signed [31:0] SIN_INC    = 32'sd971550650;
    localparam logic signed [31:0] HALF_SQRT3 = 32'sd929887697;
    localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
    localparam logic signed [31:0] Q30_HALF   = 32'sd536870912;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    function automatic ang_t atan_lut(input int unsigned i);
        case (i)
            0: return 34'sd536870912;
            1: return 34'sd316933406;
            2: return 34'sd167458907;
            3: return 34'sd85004756;
            4: return 34'sd42667331;
            5: return 34'sd21354465;
            6: return 34'sd10679838;
            7: return 34'sd5340245;
            8: return 34'sd2670163;
            9: return 34'sd1335087;
            10: return 34'sd667544;
            11: return 34'sd333772;
            12: return 34'sd166886;
            13: return 34'sd83443;
            14: return 34'sd41722;
            15: return 34'sd20861;
            16: return 34'sd10430;
            17: return 34'sd5215;
            18: return 34'sd2608;
            19: return 34'sd1304;
            20: return 34'sd652;
            21: return 34'sd326;
            22: return 34'sd163;
            23: return 34'sd81;
            24: return 34'sd41;
            25: return 34'sd20;
            26: return 34'sd10;
            27: return 34'sd5;
            28: return 34'sd3;
            29: return 34'sd1;
            default: return '0;
        endcase
    endfunction

    // phase of a whole-degree angle, 2^-48 turn, ties rounded up
    function automatic logic [47:0] start_of_deg(input int unsigned deg);
        logic [56:0] num;
        begin
            num = (57'(deg) << 48) + 57'd180;
            return 48'(num / 57'd360);
        end
    endfunction

    // start phase of slot index 0..23, 2^-48 turn
    function automatic logic [47:0] start_lut(input logic [4:0] idx);
        case (idx)
            5'd0:  return start_of_deg(0);
            5'd1:  return start_of_deg(315);
            5'd2:  return start_of_deg(270);
            5'd3:  return start_of_deg(225);
            5'd4:  return start_of_deg(180);
            5'd5:  return start_of_deg(135);
            5'd6:  return start_of_deg(90);
            5'd7:  return start_of_deg(45);
            5'd8:  return start_of_deg(15);
            5'd9:  return start_of_deg(330);
            5'd10: return start_of_deg(285);
            5'd11: return start_of_deg(240);
            5'd12: return start_of_deg(195);
            5'd13: return start_of_deg(150);
            5'd14: return start_of_deg(105);
            5'd15: return start_of_deg(60);
            5'd16: return start_of_deg(30);
            5'd17: return start_of_deg(345);
            5'd18: return start_of_deg(300);
            5'd19: return start_of_deg(255);
            5'd20: return start_of_deg(210);
            5'd21: return start_of_deg(165);
            5'd22: return start_of_deg(120);
            5'd23: return start_of_deg(75);
            default: return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ src/circular_orbit_satellite_position_unit.sv @@
`default_nettype none
// circular-orbit satellite position: a request carries a slot (1..24) and a signed
// time in seconds; the result is X, Y, Z in metres on a 25478136 m orbit, rounded to
// nearest, plus slot_ok (zero coordinates for a bad slot). fully pipelined: one
// request per cycle while not stalled; register stages: phase multiply 2, unrolled
// cordic 31, rotation and scaling multiplies 4. a stall freezes the whole pipe; the output
// register accepts a new result whenever it is empty or being taken.
module circular_orbit_satellite_position_unit #(
    parameter int NUM_SLOTS  = 24,
    parameter int PHASE_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // slot[4:0], time_s[36:5], zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata    // pos_x, pos_y, pos_z, slot_ok, zero pad
);
    localparam int N  = cosp_pkg::CORDIC_ITERS;
    localparam int VW = cosp_pkg::VEC_W;
    localparam logic [47:0] PH_MASK = ~((48'd1 << (48 - PHASE_BITS)) - 48'd1);

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage a: decode slot, register time
    logic               a_v_reg, a_ok_reg;
    logic [1:0]         a_pl_reg;
    logic [47:0]        a_st_reg;
    logic signed [31:0] a_t_reg;
    logic [4:0]         in_slot, in_idx;
    logic               in_ok;
    assign in_slot = s_axis_tdata[4:0];
    assign in_ok   = (in_slot >= 5'd1) && (32'(in_slot) <= NUM_SLOTS) && (in_slot <= 5'd24);
    assign in_idx  = in_slot - 5'd1;

    // stage b: phase product
    logic        b_v_reg, b_ok_reg;
    logic [1:0]  b_pl_reg;
    logic [47:0] b_ph_reg;

    // cordic pipe
    logic                 c_v_reg [N+1];
    logic                 c_ok_reg[N+1];
    logic                 c_fl_reg[N+1];
    logic [1:0]           c_pl_reg[N+1];
    cosp_pkg::vec_t       c_x_reg [N+1];
    cosp_pkg::vec_t       c_y_reg [N+1];
    cosp_pkg::ang_t       c_z_reg [N+1];

    logic [47:0] ph_cut;
    logic [31:0] ang, ang_f;
    logic        flip;
    assign ph_cut = b_ph_reg & PH_MASK;
    assign ang    = ph_cut[47:16];
    assign flip   = ang[31] ^ ang[30];
    assign ang_f  = flip ? ang - 32'h8000_0000 : ang;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                c_v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_v_reg <= s_axis_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg[0] <= b_v_reg;
            for (int i = 1; i <= N; i++)
            begin
                c_v_reg[i] <= c_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg <= in_ok;
            a_pl_reg <= 2'(in_idx >> 3);
            a_st_reg <= cosp_pkg::start_lut(in_idx);
            a_t_reg  <= s_axis_tdata[36:5];
            b_ok_reg <= a_ok_reg;
            b_pl_reg <= a_pl_reg;
            b_ph_reg <= a_st_reg + 48'($signed(a_t_reg) * $signed({1'b0, cosp_pkg::RATE48}));
            c_ok_reg[0] <= b_ok_reg;
            c_pl_reg[0] <= b_pl_reg;
            c_fl_reg[0] <= flip;
            c_x_reg[0]  <= cosp_pkg::CORDIC_K;
            c_y_reg[0]  <= '0;
            c_z_reg[0]  <= cosp_pkg::ang_t'($signed(ang_f));
            for (int i = 0; i < N; i++)
            begin
                c_ok_reg[i+1] <= c_ok_reg[i];
                c_pl_reg[i+1] <= c_pl_reg[i];
                c_fl_reg[i+1] <= c_fl_reg[i];
                if (!c_z_reg[i][cosp_pkg::ANG_W-1])
                begin
                    c_x_reg[i+1] <= c_x_reg[i] - (c_y_reg[i] >>> i);
                    c_y_reg[i+1] <= c_y_reg[i] + (c_x_reg[i] >>> i);
                    c_z_reg[i+1] <= c_z_reg[i] - cosp_pkg::atan_lut(i);
                end
                else
                begin
                    c_x_reg[i+1] <= c_x_reg[i] + (c_y_reg[i] >>> i);
                    c_y_reg[i+1] <= c_y_reg[i] - (c_x_reg[i] >>> i);
                    c_z_reg[i+1] <= c_z_reg[i] + cosp_pkg::atan_lut(i);
                end
            end
        end
    end

    // rotation stages: d = fold + inclination, e = node products, f = sum, g = radius
    logic signed [VW-1:0] fc, fs;
    assign fc = c_fl_reg[N] ? -c_x_reg[N] : c_x_reg[N];
    assign fs = c_fl_reg[N] ? -c_y_reg[N] : c_y_reg[N];

    logic               d_v_reg, d_ok_reg, e_v_reg, e_ok_reg, f_v_reg, f_ok_reg;
    logic [1:0]         d_pl_reg;
    logic signed [VW-1:0] d_c_reg;
    logic signed [65:0] d_a_reg, d_e_reg;
    logic signed [66:0] e_cc_reg, e_cs_reg, e_ac_reg, e_as_reg;
    logic signed [35:0] e_e_reg;
    logic signed [35:0] f_x_reg, f_y_reg, f_z_reg;
    logic signed [35:0] a_q;
    logic signed [31:0] cos_o, sin_o;

    assign a_q = 36'(((d_a_reg + 66'sd536870912) >>> 30));

    always_comb
    begin
        case (d_pl_reg)
            2'd0:
            begin
                cos_o = cosp_pkg::Q30_ONE;
                sin_o = '0;
            end
            2'd1:
            begin
                cos_o = -cosp_pkg::Q30_HALF;
                sin_o = cosp_pkg::HALF_SQRT3;
            end
            default:
            begin
                cos_o = -cosp_pkg::Q30_HALF;
                sin_o = -cosp_pkg::HALF_SQRT3;
            end
        endcase
    end

    logic signed [67:0] tx_s, ty_s;
    assign tx_s = 68'(e_cc_reg) - 68'(e_as_reg);
    assign ty_s = 68'(e_cs_reg) + 68'(e_ac_reg);

    logic signed [63:0] g_x, g_y, g_z;
    assign g_x = 64'(f_x_reg) * 64'(cosp_pkg::ORBIT_R);
    assign g_y = 64'(f_y_reg) * 64'(cosp_pkg::ORBIT_R);
    assign g_z = 64'(f_z_reg) * 64'(cosp_pkg::ORBIT_R);

    function automatic logic [25:0] rsat(input logic signed [63:0] p);
        logic signed [63:0] r;
        begin
            r = (p + 64'sd536870912) >>> 30;
            if (r > 64'(cosp_pkg::ORBIT_R))
                return 26'(cosp_pkg::ORBIT_R);
            else if (r < -64'(cosp_pkg::ORBIT_R))
                return 26'(-cosp_pkg::ORBIT_R);
            return r[25:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= c_v_reg[N];
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            m_axis_tvalid <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_ok_reg <= c_ok_reg[N];
            d_pl_reg <= c_pl_reg[N];
            d_c_reg  <= fc;
            d_a_reg  <= 66'(fs * cosp_pkg::COS_INC);
            d_e_reg  <= 66'(fs * cosp_pkg::SIN_INC);
            e_ok_reg <= d_ok_reg;
            e_cc_reg <= 67'(d_c_reg * cos_o);
            e_cs_reg <= 67'(d_c_reg * sin_o);
            e_ac_reg <= 67'(a_q * cos_o);
            e_as_reg <= 67'(a_q * sin_o);
            e_e_reg  <= 36'(((d_e_reg + 66'sd536870912) >>> 30));
            f_ok_reg <= e_ok_reg;
            f_x_reg  <= 36'(((tx_s + 68'sd536870912) >>> 30));
            f_y_reg  <= 36'(((ty_s + 68'sd536870912) >>> 30));
            f_z_reg  <= e_e_reg;
            m_axis_tdata[25:0]  <= f_ok_reg ? rsat(g_x) : '0;
            m_axis_tdata[51:26] <= f_ok_reg ? rsat(g_y) : '0;
            m_axis_tdata[77:52] <= f_ok_reg ? rsat(g_z) : '0;
            m_axis_tdata[78]    <= f_ok_reg;
            m_axis_tdata[79]    <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[78] |-> m_axis_tdata[77:0] == '0)
        else $error("bad slot with nonzero coordinates");

endmodule
`default_nettype wire
